// ===== rtl/typed_checked_integer_alu_unit_defines.svh =====
// Assertion macros for the typed checked integer ALU
`ifndef TYPED_CHECKED_INTEGER_ALU_UNIT_DEFINES_SVH
`define TYPED_CHECKED_INTEGER_ALU_UNIT_DEFINES_SVH

// same-cycle implication
`define TCIA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tcia_pkg.sv =====
// Types, codes and range helpers for the typed checked integer ALU
`default_nettype none
package tcia_pkg;
	localparam int DivSteps = 32;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_MOD = 3'd4;

	localparam logic [1:0] TY_INT8  = 2'd0;
	localparam logic [1:0] TY_INT16 = 2'd1;
	localparam logic [1:0] TY_INT32 = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_OVERFLOW  = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW = 3'd2;
	localparam logic [2:0] ST_DIV_ZERO  = 3'd3;
	localparam logic [2:0] ST_OPERAND   = 3'd4;

	localparam logic signed [63:0] I8_LO   = -64'sd128;
	localparam logic signed [63:0] I8_HI   = 64'sd127;
	localparam logic signed [63:0] I16_LO  = -64'sd32768;
	localparam logic signed [63:0] I16_HI  = 64'sd32767;
	localparam logic signed [63:0] INT_MIN = -64'sd2147483648;
	localparam logic signed [63:0] INT_MAX = 64'sd2147483647;

	typedef struct packed {
		logic [2:0]         operation;
		logic [1:0]         type_a;
		logic signed [31:0] value_a;
		logic [1:0]         type_b;
		logic signed [31:0] value_b;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0]         result_type;
		logic [2:0]         status;
	} res_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [1:0]         tr;
		logic [2:0]         status;
		logic signed [63:0] arith;
		logic               neg_q;
		logic               neg_r;
		logic [31:0]        divisor;
		logic [31:0]        rem;
		logic [31:0]        quo;
	} pipe_t;

	function automatic logic signed [63:0] type_lo(input logic [1:0] t);
		logic signed [63:0] lo;
		case (t)
			TY_INT8:  lo = I8_LO;
			TY_INT16: lo = I16_LO;
			default:  lo = INT_MIN;
		endcase
		return lo;
	endfunction

	function automatic logic signed [63:0] type_hi(input logic [1:0] t);
		logic signed [63:0] hi;
		case (t)
			TY_INT8:  hi = I8_HI;
			TY_INT16: hi = I16_HI;
			default:  hi = INT_MAX;
		endcase
		return hi;
	endfunction

	function automatic logic operand_ok(input logic [1:0] t, input logic [31:0] v);
		logic ok;
		case (t)
			TY_INT8:  ok = (&v[31:7]) | ~(|v[31:7]);
			TY_INT16: ok = (&v[31:15]) | ~(|v[31:15]);
			TY_INT32: ok = 1'b1;
			default:  ok = 1'b0;
		endcase
		return ok;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/tcia_front.sv =====
// Front stages: request capture, operand checks, add/sub/mul and divider setup
`default_nettype none
module tcia_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           req_valid,
	input  wire tcia_pkg::req_t req,
	output logic                valid_out,
	output tcia_pkg::pipe_t     pipe_out
);
	import tcia_pkg::*;

	logic  valid_s1, valid_s2;
	req_t  req_s1;
	pipe_t pipe_s2;
	pipe_t nxt;
	logic  ok_ops;
	logic  [1:0] tmax;
	logic  signed [63:0] sa, sb;

	always_comb begin
		sa = {{32{req_s1.value_a[31]}}, req_s1.value_a};
		sb = {{32{req_s1.value_b[31]}}, req_s1.value_b};
		tmax = (req_s1.type_a >= req_s1.type_b) ? req_s1.type_a : req_s1.type_b;
		ok_ops = operand_ok(req_s1.type_a, req_s1.value_a) &
			operand_ok(req_s1.type_b, req_s1.value_b);
		nxt.op = req_s1.operation;
		nxt.tr = (tmax > TY_INT32) ? TY_INT32 : tmax;
		if (!ok_ops) begin
			nxt.status = ST_OPERAND;
		end else if ((req_s1.operation == OP_DIV || req_s1.operation == OP_MOD) &&
			req_s1.value_b == 32'sd0) begin
			nxt.status = ST_DIV_ZERO;
		end else begin
			nxt.status = ST_OK;
		end
		case (req_s1.operation)
			OP_ADD:  nxt.arith = sa + sb;
			OP_SUB:  nxt.arith = sa - sb;
			OP_MUL:  nxt.arith = req_s1.value_a * sb;
			default: nxt.arith = 64'sd0;
		endcase
		nxt.neg_q = req_s1.value_a[31] ^ req_s1.value_b[31];
		nxt.neg_r = req_s1.value_a[31];
		nxt.divisor = req_s1.value_b[31] ? 32'(-req_s1.value_b) : req_s1.value_b;
		nxt.quo = req_s1.value_a[31] ? 32'(-req_s1.value_a) : req_s1.value_a;
		nxt.rem = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1  <= req;
			pipe_s2 <= nxt;
		end
	end

	assign valid_out = valid_s2;
	assign pipe_out  = pipe_s2;
endmodule
`default_nettype wire

// ===== rtl/tcia_div_stage.sv =====
// One restoring-division step with its pipeline register
`default_nettype none
module tcia_div_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            valid_in,
	input  wire tcia_pkg::pipe_t pipe_in,
	output logic                 valid_out,
	output tcia_pkg::pipe_t      pipe_out
);
	import tcia_pkg::*;

	logic  valid_s1;
	pipe_t step_s1;
	pipe_t nxt;
	logic  [32:0] shifted, diff;

	always_comb begin
		nxt = pipe_in;
		shifted = {pipe_in.rem, pipe_in.quo[31]};
		diff = shifted - {1'b0, pipe_in.divisor};
		if (!diff[32]) begin
			nxt.rem = diff[31:0];
			nxt.quo = {pipe_in.quo[30:0], 1'b1};
		end else begin
			nxt.rem = shifted[31:0];
			nxt.quo = {pipe_in.quo[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			step_s1 <= nxt;
		end
	end

	assign valid_out = valid_s1;
	assign pipe_out  = step_s1;
endmodule
`default_nettype wire

// ===== rtl/tcia_back.sv =====
// Back stages: sign fixup, result select, range check and output register
`default_nettype none
module tcia_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            valid_in,
	input  wire tcia_pkg::pipe_t pipe_in,
	output logic                 res_valid,
	output tcia_pkg::res_t       res
);
	import tcia_pkg::*;

	logic  valid_s1, valid_s2;
	logic  signed [63:0] val_s1;
	logic  [1:0] tr_s1;
	logic  [2:0] st_s1;
	res_t  res_s2;
	logic  signed [63:0] val_nxt, uq, ur;
	res_t  res_nxt;

	always_comb begin
		uq = {32'd0, pipe_in.quo};
		ur = {32'd0, pipe_in.rem};
		case (pipe_in.op) inside
			OP_ADD, OP_SUB, OP_MUL: val_nxt = pipe_in.arith;
			OP_DIV:  val_nxt = pipe_in.neg_q ? -uq : uq;
			OP_MOD:  val_nxt = pipe_in.neg_r ? -ur : ur;
			default: val_nxt = 64'sd0;
		endcase
	end

	always_comb begin
		res_nxt.result_type = tr_s1;
		res_nxt.status = st_s1;
		if (st_s1 == ST_OK) begin
			if (val_s1 < type_lo(tr_s1)) begin
				res_nxt.status = ST_UNDERFLOW;
			end else if (val_s1 > type_hi(tr_s1)) begin
				res_nxt.status = ST_OVERFLOW;
			end
		end
		res_nxt.result_value = (res_nxt.status == ST_OK) ? val_s1[31:0] : 32'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s1 <= val_nxt;
			tr_s1  <= pipe_in.tr;
			st_s1  <= pipe_in.status;
			res_s2 <= res_nxt;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;
endmodule
`default_nettype wire

// ===== rtl/typed_checked_integer_alu_unit.sv =====
// 36 pipeline stages from request accept to result valid (2 front, 32 divide, 2 back).
// Throughput: one request per cycle while the result is not stalled; every operation runs through the full pipeline.
// The 32-step divide pipeline, one quotient bit per stage, sets the latency.
// A stalled result freezes the whole pipeline; no request is lost or repeated.
// Reset clears all valid bits asynchronously; payload registers are not reset.
`default_nettype none
module typed_checked_integer_alu_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire tcia_pkg::req_t req,
	output logic                res_valid,
	input  wire logic           res_stall,
	output tcia_pkg::res_t      res
);
	import tcia_pkg::*;

	logic  adv;
	logic  v  [0:DivSteps];
	pipe_t p  [0:DivSteps];

	assign adv       = !(res_valid && res_stall);
	assign req_stall = !adv;

	tcia_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req_valid (req_valid),
		.req       (req),
		.valid_out (v[0]),
		.pipe_out  (p[0])
	);

	for (genvar i = 0; i < DivSteps; i++) begin : g_div
		tcia_div_stage u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.valid_in  (v[i]),
			.pipe_in   (p[i]),
			.valid_out (v[i+1]),
			.pipe_out  (p[i+1])
		);
	end

	tcia_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (v[DivSteps]),
		.pipe_in   (p[DivSteps]),
		.res_valid (res_valid),
		.res       (res)
	);
endmodule
`default_nettype wire

// ===== rtl/tcia_checker.sv =====
// Port-level checker for the typed checked integer ALU, bound to the top level
`default_nettype none
`include "typed_checked_integer_alu_unit_defines.svh"
module tcia_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           req_stall,
	input  wire tcia_pkg::req_t req,
	input  wire logic           res_valid,
	input  wire logic           res_stall,
	input  wire tcia_pkg::res_t res
);
	import tcia_pkg::*;

	`TCIA_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")
	`TCIA_ASSERT_NEXT(a_req_hold, clk, arst_n, req_valid && req_stall, req_valid && $stable(req), "stalled request changed")
	`TCIA_ASSERT_NOW(a_backpressure, clk, arst_n, res_valid && res_stall, req_stall, "request taken while result stalled")
	`TCIA_ASSERT_NOW(a_no_idle_stall, clk, arst_n, !res_valid, !req_stall, "request stalled with empty output")
	`TCIA_ASSERT_NOW(a_err_zero, clk, arst_n, res_valid && res.status != ST_OK, res.result_value == 32'sd0, "error result not zero")
endmodule

bind typed_checked_integer_alu_unit tcia_checker u_tcia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the typed checked integer ALU: random and directed requests, scoreboard check
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import tcia_pkg::*;

	class alu_scoreboard;
		res_t pending[$];
		int   errors;

		function void note_request(req_t r);
			logic [1:0]         tr;
			logic [2:0]         st;
			logic signed [63:0] a, b, v, lo, hi;
			tr = (r.type_a >= r.type_b) ? r.type_a : r.type_b;
			if (tr > TY_INT32)
				tr = TY_INT32;
			a = 64'(r.value_a);
			b = 64'(r.value_b);
			v = 0;
			st = ST_OK;
			if (!fits(r.type_a, a) || !fits(r.type_b, b))
				st = ST_OPERAND;
			else if ((r.operation == OP_DIV || r.operation == OP_MOD) && b == 0)
				st = ST_DIV_ZERO;
			else begin
				case (r.operation)
					OP_ADD: v = a + b;
					OP_SUB: v = a - b;
					OP_MUL: v = a * b;
					OP_DIV: v = a / b;
					OP_MOD: v = a % b;
					default: v = 0;
				endcase
				bounds(tr, lo, hi);
				if (v < lo)
					st = ST_UNDERFLOW;
				else if (v > hi)
					st = ST_OVERFLOW;
			end
			if (st != ST_OK)
				v = 0;
			pending.push_back('{result_value: v[31:0], result_type: tr, status: st});
		endfunction

		function void bounds(logic [1:0] t, output logic signed [63:0] lo,
				output logic signed [63:0] hi);
			case (t)
				TY_INT8: begin lo = -128; hi = 127; end
				TY_INT16: begin lo = -32768; hi = 32767; end
				default: begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
			endcase
		endfunction

		function bit fits(logic [1:0] t, logic signed [63:0] v);
			logic signed [63:0] lo, hi;
			if (t > TY_INT32)
				return 0;
			bounds(t, lo, hi);
			return v >= lo && v <= hi;
		endfunction

		function void check_result(res_t got);
			res_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result %p", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.result_value !== exp.result_value) begin
				$error("result_value exp %0d got %0d", exp.result_value, got.result_value);
				errors++;
			end
			if (got.result_type !== exp.result_type) begin
				$error("result_type exp %0d got %0d", exp.result_type, got.result_type);
				errors++;
			end
			if (got.status !== exp.status) begin
				$error("status exp %0d got %0d", exp.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic   clk = 0;
	logic   arst_n = 0;
	logic   req_valid = 0;
	logic   req_stall;
	req_t   req = '0;
	logic   res_valid;
	logic   res_stall = 0;
	res_t   res;
	int     cycles = 0;
	bit     hold_rx = 0;
	bit     done = 0;
	alu_scoreboard sb = new();

	typed_checked_integer_alu_unit dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req(req), .res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always #5 clk = ~clk;

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	function automatic logic [31:0] pick_value(logic [1:0] t);
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 0;
			3: return -1;
			4: return $urandom();
			5: return $urandom_range(0, 7) - 4;
			default:
				case (t)
					TY_INT8: return $signed($urandom_range(0, 255) - 128);
					TY_INT16: return $signed($urandom_range(0, 65535) - 32768);
					default: return $urandom();
				endcase
		endcase
	endfunction

	task automatic send(req_t r);
		req <= r;
		req_valid <= 1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic idle(int n);
		if (n > 0) begin
			req_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_random(bit sane);
		req_t r;
		r.operation = sane ? 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 7));
		r.type_a = sane ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 3));
		r.type_b = sane ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 3));
		r.value_a = pick_value(r.type_a);
		r.value_b = pick_value(r.type_b);
		send(r);
	endtask

	task automatic directed();
		logic [31:0] vals[6];
		vals = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ff80, 32'h7f, 32'hffff_8000, 0};
		send('{OP_DIV, TY_INT32, 32'h8000_0000, TY_INT32, -1});
		send('{OP_MOD, TY_INT32, 32'h8000_0000, TY_INT32, -1});
		send('{OP_DIV, TY_INT8, 5, TY_INT8, 0});
		send('{OP_MOD, TY_INT16, -7, TY_INT8, 2});
		send('{OP_DIV, TY_INT16, -7, TY_INT8, 2});
		send('{OP_ADD, TY_INT8, 127, TY_INT8, 1});
		send('{OP_SUB, TY_INT8, -128, TY_INT8, 1});
		send('{OP_MUL, TY_INT16, 32767, TY_INT16, 32767});
		send('{OP_MUL, TY_INT32, 32'h8000_0000, TY_INT32, 32'h7fff_ffff});
		send('{OP_ADD, TY_INT8, 128, TY_INT8, 0});
		send('{OP_ADD, 2'd3, 0, TY_INT8, 0});
		send('{3'd5, TY_INT8, 1, TY_INT8, 1});
		send('{3'd7, 2'd3, 32'hffff_ffff, 2'd3, 32'hffff_ffff});
		foreach (vals[i])
			send('{OP_SUB, TY_INT32, vals[i], TY_INT16, vals[5 - i]});
		send('{OP_ADD, TY_INT32, 32'h7fff_ffff, TY_INT32, 32'h7fff_ffff});
		send('{OP_SUB, TY_INT32, 32'h8000_0000, TY_INT8, 1});
	endtask

	task automatic wait_drain();
		req_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed();
		wait_drain();
		for (int i = 0; i < 2000; i++) begin
			if (i == 600) begin
				hold_rx <= 1;
				repeat (80) send_random(1);
				hold_rx <= 0;
			end
			if (i == 1200)
				wait_drain();
			send_random($urandom_range(0, 9) != 0);
			if ($urandom_range(0, 3) == 0 && !(i > 800 && i < 1000))
				idle(gap_len());
		end
		wait_drain();
		repeat (60) @(posedge clk);
		done <= 1;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res);
	end

	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				res_stall <= 1;
				repeat (150) @(posedge clk);
				res_stall <= 0;
				while (hold_rx)
					@(posedge clk);
			end else if ($urandom_range(0, 4) == 0) begin
				n = gap_len();
				res_stall <= n > 0;
				repeat (n) @(posedge clk);
				res_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done) begin
			if (sb.errors == 0 && sb.pending.size() == 0)
				$display("[typed_checked_integer_alu_unit] OK");
			else
				$display("[typed_checked_integer_alu_unit] ERROR");
			$finish;
		end else if (cycles > 400000) begin
			$display("[typed_checked_integer_alu_unit] ERROR");
			$finish;
		end
	end
endmodule
`default_nettype wire
